>>> hw/rtl/sbm_pkg.sv
// sbm_pkg: shared types and constants for the simple byte machine executor
// holds command codes, opcodes and the request/response structs of the shared alu
// no dependencies
package sbm_pkg;

  // field widths
  localparam int unsigned AddrW   = 8;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned RegIdxW = 4;
  localparam int unsigned InstrW  = 16;
  localparam int unsigned CmdW    = 2;
  localparam int unsigned OpW     = 4;

  // command codes
  typedef logic [CmdW-1:0] cmd_t;
  localparam cmd_t CMD_WRITE   = 2'd0;
  localparam cmd_t CMD_EXEC    = 2'd1;
  localparam cmd_t CMD_RESTART = 2'd2;

  // instruction opcodes (top nibble of the instruction word)
  typedef logic [OpW-1:0] opcode_t;
  localparam opcode_t OP_LOAD  = 4'h1;
  localparam opcode_t OP_LOADI = 4'h2;
  localparam opcode_t OP_STORE = 4'h3;
  localparam opcode_t OP_MOVE  = 4'h4;
  localparam opcode_t OP_ADD   = 4'h5;
  localparam opcode_t OP_JUMP  = 4'hB;
  localparam opcode_t OP_HALT  = 4'hC;

  // shared alu interface
  typedef struct packed {
    logic [ByteW-1:0] a;
    logic [ByteW-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [ByteW-1:0] sum;
    logic             eq;
  } alu_rsp_t;

endpackage

>>> hw/rtl/sbm_alu.sv
// sbm_alu: shared byte arithmetic unit of the executor
// gives the wrapping byte sum and the equality compare of two operands
// depends on sbm_pkg
module sbm_alu (
  input  sbm_pkg::alu_req_t req,
  output sbm_pkg::alu_rsp_t rsp
);
  import sbm_pkg::*;

  // modulo 256 add and compare, used by add and jump instructions
  assign rsp.sum = req.a + req.b;
  assign rsp.eq  = (req.a == req.b);

endmodule

>>> hw/rtl/simple_byte_machine_executor.sv
// simple_byte_machine_executor: top level of the byte machine executor
// holds the sequencer, the single-port byte memory and the register file
// depends on sbm_pkg and sbm_alu
//
// Each input transaction is one command: write a memory byte, execute one
// instruction at the program counter, or restart at the start address. Every
// transaction returns exactly one result with pc, the last instruction word,
// the halt flag, memory[address] and register[reg_index] as they stand after
// the command. The block takes one transaction at a time: a write passes the
// write and report states; a restart, an unused command 3 or an execute while
// halted goes straight to the report; a running execute fetches, decodes and
// executes first. The sequence is set by the single-port 256-byte memory (two
// fetch reads, a data access and a report read each need their own access) and
// by the one read port of the register file, which reads the two operands of
// add and jump in turn into a shared alu. A stalled result waits for a free
// result register. After reset the block clears memory and registers to zero
// with in_stall high; configuration writes are taken at all times.
module simple_byte_machine_executor (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [7:0]  in_address,
  input  logic [7:0]  in_data,
  input  logic [3:0]  in_reg_index,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_pc,
  output logic [15:0] out_instruction,
  output logic        out_halted,
  output logic [7:0]  out_mem_value,
  output logic [7:0]  out_reg_value,
  // configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);
  import sbm_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WR,
    ST_F1,
    ST_F2,
    ST_DEC,
    ST_EXA,
    ST_EXB,
    ST_EXC,
    ST_RPT,
    ST_FIN
  } state_t;

  state_t state_r, state_nxt;

  // latched transaction
  logic [AddrW-1:0]   addr_r, addr_nxt;
  logic [ByteW-1:0]   data_r, data_nxt;
  logic [RegIdxW-1:0] ridx_r, ridx_nxt;

  // architectural state
  logic [AddrW-1:0]   pc_r, pc_nxt;
  logic [InstrW-1:0]  ir_r, ir_nxt;
  logic               halt_r, halt_nxt;
  logic [AddrW-1:0]   start_r, start_nxt;

  // working registers
  logic [ByteW-1:0]   hi_r, hi_nxt;
  logic [ByteW-1:0]   a_r, a_nxt;
  logic [AddrW-1:0]   clr_cnt_r, clr_cnt_nxt;

  // result register
  logic               out_valid_r, out_valid_nxt;
  logic [AddrW-1:0]   out_pc_r, out_pc_nxt;
  logic [InstrW-1:0]  out_ir_r, out_ir_nxt;
  logic               out_halt_r, out_halt_nxt;
  logic [ByteW-1:0]   out_mem_r, out_mem_nxt;
  logic [ByteW-1:0]   out_reg_r, out_reg_nxt;

  // memory and register file ports
  logic               mem_we;
  logic [AddrW-1:0]   mem_addr;
  logic [ByteW-1:0]   mem_wd;
  logic [ByteW-1:0]   mem_q;
  logic               rf_we;
  logic [RegIdxW-1:0] rf_waddr;
  logic [ByteW-1:0]   rf_wd;
  logic [RegIdxW-1:0] rf_raddr;
  logic [ByteW-1:0]   rf_q;

  logic [ByteW-1:0]   mem [2**AddrW];
  logic [ByteW-1:0]   rf  [2**RegIdxW];

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  // instruction fields
  opcode_t            op;
  logic [RegIdxW-1:0] fld_r, fld_s, fld_t;
  logic [ByteW-1:0]   fld_lo;
  logic               in_acc;

  assign op     = ir_r[15:12];
  assign fld_r  = ir_r[11:8];
  assign fld_s  = ir_r[7:4];
  assign fld_t  = ir_r[3:0];
  assign fld_lo = ir_r[7:0];

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign out_valid       = out_valid_r;
  assign out_pc          = out_pc_r;
  assign out_instruction = out_ir_r;
  assign out_halted      = out_halt_r;
  assign out_mem_value   = out_mem_r;
  assign out_reg_value   = out_reg_r;

  // shared add / compare unit
  assign alu_req.a = a_r;
  assign alu_req.b = rf_q;

  sbm_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    data_nxt      = data_r;
    ridx_nxt      = ridx_r;
    pc_nxt        = pc_r;
    ir_nxt        = ir_r;
    halt_nxt      = halt_r;
    start_nxt     = start_r;
    hi_nxt        = hi_r;
    a_nxt         = a_r;
    clr_cnt_nxt   = clr_cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_pc_nxt    = out_pc_r;
    out_ir_nxt    = out_ir_r;
    out_halt_nxt  = out_halt_r;
    out_mem_nxt   = out_mem_r;
    out_reg_nxt   = out_reg_r;

    // default ports keep the report reads pointed at the item's address
    mem_we   = 1'b0;
    mem_addr = addr_r;
    mem_wd   = data_r;
    rf_we    = 1'b0;
    rf_waddr = fld_r;
    rf_wd    = a_r;
    rf_raddr = ridx_r;

    // configuration write
    if (cfg_valid && cfg_ready) begin
      start_nxt = cfg_data;
    end

    case (state_r)
      // zero memory and registers after reset
      ST_CLEAR: begin
        mem_we      = 1'b1;
        mem_addr    = clr_cnt_r;
        mem_wd      = '0;
        rf_we       = 1'b1;
        rf_waddr    = clr_cnt_r[RegIdxW-1:0];
        rf_wd       = '0;
        clr_cnt_nxt = clr_cnt_r + 8'd1;
        if (clr_cnt_r == 8'hFF) begin
          state_nxt = ST_IDLE;
        end
      end

      // take a new transaction
      ST_IDLE: begin
        if (in_acc) begin
          addr_nxt = in_address;
          data_nxt = in_data;
          ridx_nxt = in_reg_index;
          case (in_command)
            CMD_WRITE: begin
              state_nxt = ST_WR;
            end
            CMD_EXEC: begin
              state_nxt = halt_r ? ST_RPT : ST_F1;
            end
            CMD_RESTART: begin
              pc_nxt    = start_r;
              halt_nxt  = 1'b0;
              state_nxt = ST_RPT;
            end
            default: begin
              state_nxt = ST_RPT;
            end
          endcase
        end
      end

      ST_WR: begin
        mem_we    = 1'b1;
        state_nxt = ST_RPT;
      end

      // fetch high byte
      ST_F1: begin
        mem_addr  = pc_r;
        state_nxt = ST_F2;
      end

      // fetch low byte, wraps past address 255
      ST_F2: begin
        mem_addr  = pc_r + 8'd1;
        hi_nxt    = mem_q;
        state_nxt = ST_DEC;
      end

      ST_DEC: begin
        ir_nxt    = {hi_r, mem_q};
        state_nxt = ST_EXA;
      end

      // first operand read: register, or memory for a load
      ST_EXA: begin
        mem_addr = fld_lo;
        case (op)
          OP_MOVE, OP_ADD: rf_raddr = fld_s;
          default:         rf_raddr = fld_r;
        endcase
        state_nxt = ST_EXB;
      end

      // latch first operand, read second
      ST_EXB: begin
        a_nxt     = (op == OP_LOAD) ? mem_q : rf_q;
        rf_raddr  = (op == OP_ADD) ? fld_t : '0;
        state_nxt = ST_EXC;
      end

      // execute and write back
      ST_EXC: begin
        pc_nxt    = pc_r + 8'd2;
        state_nxt = ST_RPT;
        case (op)
          OP_LOAD: begin
            rf_we = 1'b1;
          end
          OP_LOADI: begin
            rf_we = 1'b1;
            rf_wd = fld_lo;
          end
          OP_STORE: begin
            mem_we   = 1'b1;
            mem_addr = fld_lo;
            mem_wd   = a_r;
          end
          OP_MOVE: begin
            rf_we    = (fld_r == '0);
            rf_waddr = fld_t;
          end
          OP_ADD: begin
            rf_we = 1'b1;
            rf_wd = alu_rsp.sum;
          end
          OP_JUMP: begin
            if (alu_rsp.eq) begin
              pc_nxt = fld_lo;
            end
          end
          OP_HALT: begin
            pc_nxt   = pc_r;
            halt_nxt = 1'b1;
          end
          default: begin
          end
        endcase
      end

      // read back memory and register for the report
      ST_RPT: begin
        state_nxt = ST_FIN;
      end

      // load the result register once it is free
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_pc_nxt    = pc_r;
          out_ir_nxt    = ir_r;
          out_halt_nxt  = halt_r;
          out_mem_nxt   = mem_q;
          out_reg_nxt   = rf_q;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      pc_r        <= '0;
      ir_r        <= '0;
      halt_r      <= 1'b0;
      start_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      pc_r        <= pc_nxt;
      ir_r        <= ir_nxt;
      halt_r      <= halt_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
    end
    addr_r     <= addr_nxt;
    data_r     <= data_nxt;
    ridx_r     <= ridx_nxt;
    hi_r       <= hi_nxt;
    a_r        <= a_nxt;
    out_pc_r   <= out_pc_nxt;
    out_ir_r   <= out_ir_nxt;
    out_halt_r <= out_halt_nxt;
    out_mem_r  <= out_mem_nxt;
    out_reg_r  <= out_reg_nxt;
  end

  // single-port byte memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wd;
    end
    mem_q <= mem[mem_addr];
  end

  // register file, one write and one registered read port
  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf[rf_waddr] <= rf_wd;
    end
    rf_q <= rf[rf_raddr];
  end

endmodule
